FILE: design/brainfuck_execute_unit_assert.svh
// assertion macros for the brainfuck execute unit
`ifndef BRAINFUCK_EXECUTE_UNIT_ASSERT_SVH
`define BRAINFUCK_EXECUTE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define BFEU_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
// next-cycle implication, checked outside reset
`define BFEU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define BFEU_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define BFEU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/bfeu_pkg.sv
// shared types and constants of the brainfuck execute unit
`timescale 1ns / 1ps

package bfeu_pkg;

  localparam int unsigned TAPE_CELLS  = 32768;
  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned PC_BITS     = 16;

  localparam int unsigned HEAD_W    = (TAPE_CELLS > 1) ? $clog2(TAPE_CELLS) : 1;
  localparam int unsigned STK_CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned STK_IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // next pc wraps within PC_BITS and is then cut to 16 bits
  localparam logic [15:0] NPC_MASK =
      (PC_BITS >= 16) ? 16'hFFFF : 16'((64'd1 << PC_BITS) - 64'd1);

  localparam logic [15:0] SKIP_MAX = 16'hFFFF;

  // command characters
  localparam logic [7:0] CMD_RIGHT = 8'h3E;  // >
  localparam logic [7:0] CMD_LEFT  = 8'h3C;  // <
  localparam logic [7:0] CMD_INC   = 8'h2B;  // +
  localparam logic [7:0] CMD_DEC   = 8'h2D;  // -
  localparam logic [7:0] CMD_OPEN  = 8'h5B;  // [
  localparam logic [7:0] CMD_CLOSE = 8'h5D;  // ]
  localparam logic [7:0] CMD_OUT   = 8'h2E;  // .
  localparam logic [7:0] CMD_IN    = 8'h2C;  // ,

  typedef logic [HEAD_W-1:0]    head_t;
  typedef logic [STK_CNT_W-1:0] stk_cnt_t;

  typedef enum logic [1:0] {
    FAULT_NONE     = 2'd0,
    FAULT_OVERFLOW = 2'd1,
    FAULT_UNDERFLOW = 2'd2,
    FAULT_TAPE_END = 2'd3
  } fault_e;

  typedef enum logic [1:0] {
    TAPE_NONE,
    TAPE_LEFT,
    TAPE_RIGHT,
    TAPE_WRITE
  } tape_op_e;

  typedef enum logic [1:0] {
    STK_NONE,
    STK_PUSH,
    STK_POP
  } stk_op_e;

  typedef struct packed {
    tape_op_e   op;
    logic [7:0] wdata;
  } tape_cmd_t;

  typedef struct packed {
    stk_op_e     op;
    logic [15:0] data;
  } stk_cmd_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic        out_valid;
    logic [7:0]  out_byte;
    fault_e      fault;
  } result_t;

endpackage

FILE: design/bfeu_if.sv
// command and result channel interfaces
`timescale 1ns / 1ps

interface bfeu_cmd_if;
  logic        valid;
  logic        ready;
  logic [7:0]  func;
  logic [15:0] pc;
  logic [7:0]  in_byte;
  logic        in_eof;

  modport source (output valid, func, pc, in_byte, in_eof, input ready);
  modport sink   (input valid, func, pc, in_byte, in_eof, output ready);
endinterface

interface bfeu_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_pc;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic [1:0]  fault;

  modport source (output valid, next_pc, out_valid, out_byte, fault, input ready);
  modport sink   (input valid, next_pc, out_valid, out_byte, fault, output ready);
endinterface

FILE: design/bfeu_tape.sv
// tape memory with a three-cell window around the head and a clear sweep
`timescale 1ns / 1ps

module bfeu_tape import bfeu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  tape_cmd_t cmd_i,
  output logic      busy_o,
  output head_t     head_o,
  output logic      at_last_o,
  output logic [7:0] cell_o
);

  localparam head_t LAST_CELL = HEAD_W'(TAPE_CELLS - 1);

  logic [7:0] tape_mem [TAPE_CELLS];
  logic [7:0] rd_q;

  logic       busy_q;
  head_t      clr_q, clr_d;
  head_t      head_q, head_d;
  logic [7:0] l_q, l_d, c_q, c_d, r_q, r_d;
  logic       l_pend_q, l_pend_d, r_pend_q, r_pend_d;
  logic [7:0] l_eff, r_eff;

  logic         mem_we, mem_re;
  head_t        mem_waddr, mem_raddr;
  logic [7:0]   mem_wdata;
  logic [HEAD_W:0] ahead2;

  assign l_eff  = l_pend_q ? rd_q : l_q;
  assign r_eff  = r_pend_q ? rd_q : r_q;
  assign ahead2 = {1'b0, head_q} + (HEAD_W + 1)'(2);

  always_comb begin
    head_d    = head_q;
    l_d       = l_eff;
    c_d       = c_q;
    r_d       = r_eff;
    l_pend_d  = 1'b0;
    r_pend_d  = 1'b0;
    clr_d     = clr_q + HEAD_W'(1);
    mem_we    = 1'b0;
    mem_waddr = head_q;
    mem_wdata = cmd_i.wdata;
    mem_re    = 1'b0;
    mem_raddr = head_q;
    if (busy_q) begin
      // sweep zeros through the whole tape
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = 8'h00;
    end else begin
      case (cmd_i.op)
        TAPE_RIGHT: begin
          head_d = head_q + HEAD_W'(1);
          l_d    = c_q;
          c_d    = r_eff;
          r_d    = r_q;
          if (ahead2 < (HEAD_W + 1)'(TAPE_CELLS)) begin
            mem_re    = 1'b1;
            mem_raddr = ahead2[HEAD_W-1:0];
            r_pend_d  = 1'b1;
          end
        end
        TAPE_LEFT: begin
          head_d = head_q - HEAD_W'(1);
          r_d    = c_q;
          c_d    = l_eff;
          l_d    = l_q;
          if (head_q >= HEAD_W'(2)) begin
            mem_re    = 1'b1;
            mem_raddr = head_q - HEAD_W'(2);
            l_pend_d  = 1'b1;
          end
        end
        TAPE_WRITE: begin
          // write-through keeps memory in step with the window
          c_d    = cmd_i.wdata;
          mem_we = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) tape_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q <= tape_mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b1;
      clr_q    <= '0;
      head_q   <= '0;
      l_q      <= 8'h00;
      c_q      <= 8'h00;
      r_q      <= 8'h00;
      l_pend_q <= 1'b0;
      r_pend_q <= 1'b0;
    end else if (busy_q) begin
      clr_q <= clr_d;
      if (clr_q == LAST_CELL) busy_q <= 1'b0;
    end else begin
      head_q   <= head_d;
      l_q      <= l_d;
      c_q      <= c_d;
      r_q      <= r_d;
      l_pend_q <= l_pend_d;
      r_pend_q <= r_pend_d;
    end
  end

  assign busy_o    = busy_q;
  assign head_o    = head_q;
  assign at_last_o = (head_q == LAST_CELL);
  assign cell_o    = c_q;

endmodule

FILE: design/bfeu_stack.sv
// loop stack memory with a cached top entry
`timescale 1ns / 1ps

module bfeu_stack import bfeu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  stk_cmd_t    cmd_i,
  output stk_cnt_t    count_o,
  output logic [15:0] top_o
);

  logic [15:0] stk_mem [STACK_DEPTH];
  logic [15:0] rd_q;
  logic [15:0] top_q, top_d, top_eff;
  logic        top_pend_q, top_pend_d;
  stk_cnt_t    cnt_q, cnt_d, below_top;
  logic        mem_re;

  assign top_eff   = top_pend_q ? rd_q : top_q;
  assign below_top = cnt_q - STK_CNT_W'(2);

  always_comb begin
    cnt_d      = cnt_q;
    top_d      = top_eff;
    top_pend_d = 1'b0;
    mem_re     = 1'b0;
    case (cmd_i.op)
      STK_PUSH: begin
        cnt_d = cnt_q + STK_CNT_W'(1);
        top_d = cmd_i.data;
      end
      STK_POP: begin
        cnt_d = cnt_q - STK_CNT_W'(1);
        // refetch the entry that becomes the new top
        if (cnt_q >= STK_CNT_W'(2)) begin
          mem_re     = 1'b1;
          top_pend_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == STK_PUSH) stk_mem[cnt_q[STK_IDX_W-1:0]] <= cmd_i.data;
    if (mem_re) rd_q <= stk_mem[below_top[STK_IDX_W-1:0]];
    top_q <= top_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      top_pend_q <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      top_pend_q <= top_pend_d;
    end
  end

  assign count_o = cnt_q;
  assign top_o   = top_eff;

endmodule

FILE: design/bfeu_obuf.sv
// two-entry result buffer between the core and the result channel
`timescale 1ns / 1ps

module bfeu_obuf import bfeu_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  result_t        data_i,
  output logic           ready_o,
  bfeu_res_if.source     res_o
);

  result_t    ent_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       pop;
  result_t    head_ent;

  assign pop      = res_o.valid & res_o.ready;
  assign ready_o  = (cnt_q != 2'd2);
  assign head_ent = ent_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

  assign res_o.valid     = (cnt_q != 2'd0);
  assign res_o.next_pc   = head_ent.next_pc;
  assign res_o.out_valid = head_ent.out_valid;
  assign res_o.out_byte  = head_ent.out_byte;
  assign res_o.fault     = 2'(head_ent.fault);

endmodule

FILE: design/brainfuck_execute_unit.sv
// top level of the brainfuck execute unit
//
//  channel | dir | payload                                 | accepted when
//  cmd_i   | in  | func, pc, in_byte, in_eof               | valid & ready
//  res_o   | out | next_pc, out_valid, out_byte, fault     | valid & ready
//
// one command word is taken per cycle while cmd_i.ready is high; the result word is
// registered into the result buffer on acceptance
// after reset the tape is swept to zero, one cell a cycle, over all TAPE_CELLS
// cells (32768); cmd_i.ready stays low during the sweep
// a two-entry result buffer lets commands keep flowing while one result waits;
// after the sweep, cmd_i.ready drops only once both entries are held by a stalled res_o
`timescale 1ns / 1ps
`include "brainfuck_execute_unit_assert.svh"

module brainfuck_execute_unit import bfeu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  bfeu_cmd_if.sink   cmd_i,
  bfeu_res_if.source res_o
);

  // tape side
  tape_cmd_t   tape_cmd;
  logic        tape_busy;
  head_t       head;
  logic        at_last;
  logic [7:0]  cur_cell;

  // loop stack side
  stk_cmd_t    stk_cmd;
  stk_cnt_t    stk_count;
  logic [15:0] stk_top;

  // skip mode for a loop entered on a zero cell
  logic        skipping_q, skipping_d;
  logic [15:0] skip_depth_q, skip_depth_d;

  logic        buf_ready;
  logic        accept;
  result_t     res_d;
  logic [15:0] npc_seq;

  assign cmd_i.ready = ~tape_busy & buf_ready;
  assign accept      = cmd_i.valid & cmd_i.ready;
  assign npc_seq     = 16'(cmd_i.pc + 16'd1) & NPC_MASK;

  // command decode and state update, all in the acceptance cycle
  always_comb begin
    res_d        = '{next_pc: npc_seq, out_valid: 1'b0, out_byte: 8'h00,
                     fault: FAULT_NONE};
    tape_cmd     = '{op: TAPE_NONE, wdata: cur_cell};
    stk_cmd      = '{op: STK_NONE, data: cmd_i.pc};
    skipping_d   = skipping_q;
    skip_depth_d = skip_depth_q;
    if (accept) begin
      if (skipping_q) begin
        // only brackets matter while passing over a loop body
        if (cmd_i.func == CMD_OPEN) begin
          if (skip_depth_q != SKIP_MAX) skip_depth_d = skip_depth_q + 16'd1;
        end else if (cmd_i.func == CMD_CLOSE) begin
          if (skip_depth_q == 16'd0) skipping_d = 1'b0;
          else skip_depth_d = skip_depth_q - 16'd1;
        end
      end else begin
        unique case (cmd_i.func)
          CMD_RIGHT: begin
            if (at_last) res_d.fault = FAULT_TAPE_END;
            else tape_cmd.op = TAPE_RIGHT;
          end
          CMD_LEFT: begin
            // left edge holds without a fault
            if (head != '0) tape_cmd.op = TAPE_LEFT;
          end
          CMD_INC: begin
            tape_cmd = '{op: TAPE_WRITE, wdata: cur_cell + 8'd1};
          end
          CMD_DEC: begin
            tape_cmd = '{op: TAPE_WRITE, wdata: cur_cell - 8'd1};
          end
          CMD_OPEN: begin
            if (cur_cell != 8'h00) begin
              if (stk_count == STK_CNT_W'(STACK_DEPTH)) res_d.fault = FAULT_OVERFLOW;
              else stk_cmd.op = STK_PUSH;
            end else begin
              skipping_d   = 1'b1;
              skip_depth_d = 16'd0;
            end
          end
          CMD_CLOSE: begin
            if (stk_count == '0) begin
              res_d.fault = FAULT_UNDERFLOW;
            end else if (cur_cell != 8'h00) begin
              // loop back: stack entry stays for the next pass
              res_d.next_pc = 16'(stk_top + 16'd1) & NPC_MASK;
            end else begin
              stk_cmd.op = STK_POP;
            end
          end
          CMD_OUT: begin
            res_d.out_valid = 1'b1;
            res_d.out_byte  = cur_cell;
          end
          CMD_IN: begin
            // end of input leaves the cell as it is
            if (!cmd_i.in_eof) tape_cmd = '{op: TAPE_WRITE, wdata: cmd_i.in_byte};
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skipping_q   <= 1'b0;
      skip_depth_q <= 16'd0;
    end else begin
      skipping_q   <= skipping_d;
      skip_depth_q <= skip_depth_d;
    end
  end

  bfeu_tape u_tape (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (tape_cmd),
    .busy_o    (tape_busy),
    .head_o    (head),
    .at_last_o (at_last),
    .cell_o    (cur_cell)
  );

  bfeu_stack u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (stk_cmd),
    .count_o (stk_count),
    .top_o   (stk_top)
  );

  bfeu_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (res_d),
    .ready_o (buf_ready),
    .res_o   (res_o)
  );

  // no command taken while the tape is being cleared
  `BFEU_ASSERT_IMPLIES(a_no_cmd_in_sweep, clk_i, rst_ni, tape_busy, !cmd_i.ready)
  // a push never goes beyond a full stack
  `BFEU_ASSERT_IMPLIES(a_push_room, clk_i, rst_ni, stk_cmd.op == STK_PUSH,
                       stk_count != STK_CNT_W'(STACK_DEPTH))
  // a pop never happens on an empty stack
  `BFEU_ASSERT_IMPLIES(a_pop_nonempty, clk_i, rst_ni, stk_cmd.op == STK_POP, stk_count != '0)
  // nesting depth is only held while skipping
  `BFEU_ASSERT_IMPLIES(a_depth_in_skip, clk_i, rst_ni, skip_depth_q != 16'd0, skipping_q)
  // an open bracket on a zero cell starts skip mode
  `BFEU_ASSERT_NEXT(a_zero_open_skips, clk_i, rst_ni,
                    accept && !skipping_q && cmd_i.func == CMD_OPEN && cur_cell == 8'h00,
                    skipping_q)

endmodule
